// File: design/ioct_pkg.sv
// Shared types and constants for the in-order completion tracker.
`timescale 1ns / 1ps
package ioct_pkg;

   localparam int MAX_RESULTS = 16;
   localparam int RET_CNT_W   = $clog2(MAX_RESULTS + 1);

   localparam logic MODE_RECORD   = 1'b0;
   localparam logic MODE_COMPLETE = 1'b1;

   typedef logic [2:0] status_type;

   localparam status_type ST_RECORDED = 3'd0;
   localparam status_type ST_FULL     = 3'd1;
   localparam status_type ST_RETIRED  = 3'd2;
   localparam status_type ST_HELD     = 3'd3;
   localparam status_type ST_UNKNOWN  = 3'd4;

   typedef struct packed {
      logic        mode;
      logic [31:0] seq;
      logic [31:0] next_page;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] retired_seq;
      logic [31:0] acked_page;
      logic        empty_res;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] seq;
      logic [31:0] next_page;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_RET_RD,
      S_RET_OUT,
      S_REPORT
   } state_type;

endpackage

// File: design/ioct_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ioct_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/ioct_seq.sv
// Sequencer: buffer pointers, done flags, one-entry-per-cycle seq compare and in-order retire.
`timescale 1ns / 1ps
module ioct_seq #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  ioct_pkg::req_type        req,
   output logic                     idle,
   input  logic                     out_free,
   output logic                     emit_vld,
   output ioct_pkg::rsp_type        emit_data,
   output logic                     ram_we,
   output logic [$clog2(DEPTH)-1:0] ram_waddr,
   output ioct_pkg::entry_type      ram_wdata,
   output logic                     ram_re,
   output logic [$clog2(DEPTH)-1:0] ram_raddr,
   input  ioct_pkg::entry_type      ram_rdata
);
   import ioct_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type             state_ff, state_in;
   logic [31:0]           seq_ff, seq_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [AW-1:0]         tail_ff, tail_in;
   logic [CW-1:0]         occ_ff, occ_in;
   logic [31:0]           ack_ff, ack_in;
   logic [DEPTH-1:0]      done_ff, done_in;
   logic [AW-1:0]         scan_idx_ff, scan_idx_in;
   logic [CW-1:0]         scan_left_ff, scan_left_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [AW-1:0]         chk_idx_ff, chk_idx_in;
   logic [RET_CNT_W-1:0]  ret_n_ff, ret_n_in;
   status_type            rep_status_ff, rep_status_in;

   logic          hit;
   logic          miss_end;
   logic          ret_go;
   logic          ret_more;
   logic [AW-1:0] head_nxt;

   function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx);
      advance = (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
   endfunction

   assign hit      = chk_vld_ff && !done_ff[chk_idx_ff] && (ram_rdata.seq == seq_ff);
   assign miss_end = chk_vld_ff && !hit && (scan_left_ff == '0);
   assign ret_go   = (occ_ff != '0) && done_ff[head_ff] &&
                     (ret_n_ff < RET_CNT_W'(MAX_RESULTS));
   assign head_nxt = advance(head_ff);
   assign ret_more = (occ_ff != CW'(1)) && done_ff[head_nxt] &&
                     (ret_n_ff < RET_CNT_W'(MAX_RESULTS - 1));
   assign idle     = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start && req.mode == MODE_COMPLETE && occ_ff != '0) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit) begin
               state_in = S_RET_RD;
            end else if (miss_end) begin
               state_in = S_REPORT;
            end
         end
         S_RET_RD: begin
            state_in = ret_go ? S_RET_OUT : S_REPORT;
         end
         S_RET_OUT: begin
            if (out_free) begin
               state_in = ret_more ? S_RET_RD : S_IDLE;
            end
         end
         S_REPORT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      seq_in        = seq_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      occ_in        = occ_ff;
      ack_in        = ack_ff;
      done_in       = done_ff;
      scan_idx_in   = scan_idx_ff;
      scan_left_in  = scan_left_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      ret_n_in      = ret_n_ff;
      rep_status_in = rep_status_ff;
      emit_vld      = 1'b0;
      emit_data.status      = ST_RECORDED;
      emit_data.retired_seq = '0;
      emit_data.acked_page  = ack_ff;
      emit_data.empty_res   = (occ_ff == '0);
      emit_data.last        = 1'b1;
      ram_we    = 1'b0;
      ram_waddr = tail_ff;
      ram_wdata.seq       = req.seq;
      ram_wdata.next_page = req.next_page;
      ram_re    = 1'b0;
      ram_raddr = scan_idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               seq_in = req.seq;
               if (req.mode == MODE_RECORD) begin
                  emit_vld = 1'b1;
                  if (occ_ff == CW'(DEPTH)) begin
                     emit_data.status = ST_FULL;
                  end else begin
                     ram_we            = 1'b1;
                     done_in[tail_ff]  = 1'b0;
                     tail_in           = advance(tail_ff);
                     occ_in            = occ_ff + CW'(1);
                     emit_data.empty_res = 1'b0;
                  end
               end else if (occ_ff == '0) begin
                  emit_vld         = 1'b1;
                  emit_data.status = ST_UNKNOWN;
               end else begin
                  scan_idx_in  = head_ff;
                  scan_left_in = occ_ff;
               end
            end
         end
         S_SCAN: begin
            if (scan_left_ff != '0) begin
               ram_re       = 1'b1;
               chk_vld_in   = 1'b1;
               chk_idx_in   = scan_idx_ff;
               scan_idx_in  = advance(scan_idx_ff);
               scan_left_in = scan_left_ff - CW'(1);
            end
            if (hit) begin
               done_in[chk_idx_ff] = 1'b1;
               ret_n_in            = '0;
            end else if (miss_end) begin
               rep_status_in = ST_UNKNOWN;
            end
         end
         S_RET_RD: begin
            if (ret_go) begin
               ram_re    = 1'b1;
               ram_raddr = head_ff;
            end else begin
               rep_status_in = ST_HELD;
            end
         end
         S_RET_OUT: begin
            if (out_free) begin
               emit_vld              = 1'b1;
               emit_data.status      = ST_RETIRED;
               emit_data.retired_seq = ram_rdata.seq;
               emit_data.acked_page  = ram_rdata.next_page;
               emit_data.empty_res   = (occ_ff == CW'(1));
               emit_data.last        = !ret_more;
               ack_in                = ram_rdata.next_page;
               done_in[head_ff]      = 1'b0;
               head_in               = head_nxt;
               occ_in                = occ_ff - CW'(1);
               ret_n_in              = ret_n_ff + RET_CNT_W'(1);
            end
         end
         S_REPORT: begin
            if (out_free) begin
               emit_vld         = 1'b1;
               emit_data.status = rep_status_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         head_ff    <= '0;
         tail_ff    <= '0;
         occ_ff     <= '0;
         ack_ff     <= '0;
         done_ff    <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         occ_ff     <= occ_in;
         ack_ff     <= ack_in;
         done_ff    <= done_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff        <= seq_in;
      scan_idx_ff   <= scan_idx_in;
      scan_left_ff  <= scan_left_in;
      chk_idx_ff    <= chk_idx_in;
      ret_n_ff      <= ret_n_in;
      rep_status_ff <= rep_status_in;
   end

endmodule

// File: design/in_order_completion_tracker.sv
// Timing: a record, a full drop or a completion on an empty buffer gives its result in the
// cycle after transfer. A completion compares one entry per cycle (entry RAM read, then
// compare); each retired entry then takes an entry RAM read, then a result, and an unknown
// or held result follows the compare through the report state.
// Throughput: one item at a time; the next transfer waits for the sequencer and result reg.
// Reset: head, tail, occupancy, done flags and acked page clear; entry RAM contents are not cleared.
`timescale 1ns / 1ps
module in_order_completion_tracker #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ioct_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ioct_pkg::rsp_type rsp_data
);
   import ioct_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff;
   logic      out_free;
   logic      seq_idle;
   logic      start;
   logic      emit_vld;
   rsp_type   emit_data;
   logic      ram_we;
   logic      ram_re;
   logic [AW-1:0] ram_waddr;
   logic [AW-1:0] ram_raddr;
   entry_type ram_wdata;
   entry_type ram_rdata;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(seq_idle && out_free);
   assign start     = req_valid && !req_stall;

   ioct_seq #(.DEPTH(DEPTH)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_data),
      .idle      (seq_idle),
      .out_free  (out_free),
      .emit_vld  (emit_vld),
      .emit_data (emit_data),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   ioct_ram #(.WIDTH($bits(entry_type)), .DEPTH(DEPTH)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid_in = emit_vld || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_vld) begin
         rsp_data_ff <= emit_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: tb/retire_checker.sv
// Retire-order checker for the tracker: predicts every result from accepted requests and compares.
`timescale 1ns / 1ps
module retire_checker #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  ioct_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  ioct_pkg::rsp_type rsp_data,
   output int unsigned       mismatches,
   output int unsigned       results_due
);
   import ioct_pkg::*;

   logic [31:0] slot_seq  [DEPTH];
   logic [31:0] slot_page [DEPTH];
   bit          slot_done [DEPTH];
   int unsigned head_slot;
   int unsigned tail_slot;
   int unsigned held_count;
   logic [31:0] acked_page;
   rsp_type     due_results [$];

   function automatic int unsigned next_slot(input int unsigned idx);
      return (idx == DEPTH - 1) ? 0 : idx + 1;
   endfunction

   task automatic queue_result(input status_type status, input logic [31:0] rseq,
                               input logic last);
      rsp_type r;
      r.status      = status;
      r.retired_seq = rseq;
      r.acked_page  = acked_page;
      r.empty_res   = (held_count == 0);
      r.last        = last;
      due_results   = {due_results, r};
   endtask

   task automatic track_request(input req_type r);
      int unsigned idx;
      int unsigned i;
      int unsigned retired;
      bit          hit;
      logic [31:0] rseq;
      if (r.mode == MODE_RECORD) begin
         if (held_count >= DEPTH) begin
            queue_result(ST_FULL, 32'h0, 1'b1);
         end else begin
            slot_seq[tail_slot]  = r.seq;
            slot_page[tail_slot] = r.next_page;
            slot_done[tail_slot] = 1'b0;
            tail_slot            = next_slot(tail_slot);
            held_count++;
            queue_result(ST_RECORDED, 32'h0, 1'b1);
         end
      end else begin
         // oldest matching entry that is still open gets marked
         hit = 1'b0;
         idx = head_slot;
         for (i = 0; i < held_count && !hit; i++) begin
            if (!slot_done[idx] && slot_seq[idx] == r.seq) begin
               slot_done[idx] = 1'b1;
               hit            = 1'b1;
            end else begin
               idx = next_slot(idx);
            end
         end
         if (!hit) begin
            queue_result(ST_UNKNOWN, 32'h0, 1'b1);
         end else begin
            retired = 0;
            while (held_count > 0 && slot_done[head_slot] && retired < MAX_RESULTS) begin
               rseq                 = slot_seq[head_slot];
               acked_page           = slot_page[head_slot];
               slot_done[head_slot] = 1'b0;
               head_slot            = next_slot(head_slot);
               held_count--;
               retired++;
               queue_result(ST_RETIRED, rseq, 1'b0);
            end
            if (retired == 0) begin
               queue_result(ST_HELD, 32'h0, 1'b1);
            end else begin
               due_results[due_results.size() - 1].last = 1'b1;
            end
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         head_slot  = 0;
         tail_slot  = 0;
         held_count = 0;
         acked_page = 32'h0;
         mismatches = 0;
         for (int k = 0; k < DEPTH; k++) begin
            slot_done[k] = 1'b0;
         end
         due_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            track_request(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               mismatches++;
               $error("result with nothing expected: status %0d retired_seq 0x%08h",
                      rsp_data.status, rsp_data.retired_seq);
            end else begin
               want = due_results.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_data.status));
               compare_field("retired_seq", want.retired_seq, rsp_data.retired_seq);
               compare_field("acked_page", want.acked_page, rsp_data.acked_page);
               compare_field("empty_res", 32'(want.empty_res), 32'(rsp_data.empty_res));
               compare_field("last", 32'(want.last), 32'(rsp_data.last));
            end
         end
      end
      results_due <= unsigned'(due_results.size());
   end

endmodule

// File: tb/tb.sv
// Top of the tracker testbench: clock, reset, request stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps
module tb;
   import ioct_pkg::*;

   localparam int DEPTH           = 16;
   localparam int RANDOM_ITEMS    = 216;
   localparam int RSP_HOLD_CYCLES = 100;
   localparam int TAIL_CYCLES     = 64;
   localparam int IDLE_LIMIT      = 2000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   int unsigned mismatches;
   int unsigned results_due;

   bit          hold_rsp;
   bit          req_calm;
   int unsigned req_calm_left;
   int unsigned items_sent;
   int unsigned quiet_cycles;
   logic [31:0] open_seqs [$];

   in_order_completion_tracker #(.DEPTH(DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   retire_checker #(.DEPTH(DEPTH)) retire_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .results_due (results_due)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stall before each transfer, calm stretches, one long hold-off
   initial begin : receiver
      int unsigned wait_left;
      int unsigned calm_left;
      bit          calm;
      bit          hold_done;
      rsp_stall <= 1'b1;
      wait_left = 0;
      calm_left = 0;
      calm      = 1'b0;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (calm_left == 0) begin
               calm      = ($urandom_range(0, 2) == 0);
               calm_left = $urandom_range(8, 32);
            end else begin
               calm_left--;
            end
            wait_left = calm ? 0 : $urandom_range(0, 14);
         end
         if (wait_left > 0) begin
            rsp_stall <= 1'b1;
            wait_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
      end
   end

   task automatic send_item(input logic mode, input logic [31:0] seq, input logic [31:0] page);
      req_type     item;
      int unsigned gap;
      item.mode      = mode;
      item.seq       = seq;
      item.next_page = page;
      if (req_calm_left == 0) begin
         req_calm      = ($urandom_range(0, 2) == 0);
         req_calm_left = $urandom_range(8, 32);
      end else begin
         req_calm_left--;
      end
      gap = req_calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] draw_seq(input int unsigned style);
      case (style)
         1: return $urandom_range(0, 7);
         2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                        : $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] draw_page();
      if ($urandom_range(0, 7) == 0) begin
         return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      end
      return $urandom;
   endfunction

   // one batch of writes recorded and completed in random order, with stray completions mixed in
   task automatic run_batch();
      int unsigned to_record;
      int unsigned style;
      int unsigned pick;
      logic [31:0] s;
      to_record = ($urandom_range(0, 9) == 0) ? $urandom_range(DEPTH - 2, DEPTH + 2)
                                               : $urandom_range(1, 8);
      style     = $urandom_range(0, 3);
      open_seqs.delete();
      while (to_record > 0 || open_seqs.size() > 0) begin
         if ($urandom_range(0, 15) == 0) begin
            send_item(MODE_COMPLETE, draw_seq(style), $urandom);
         end else if (to_record > 0 && (open_seqs.size() == 0 || $urandom_range(0, 2) != 0)) begin
            s = draw_seq(style);
            send_item(MODE_RECORD, s, draw_page());
            open_seqs = {open_seqs, s};
            to_record--;
         end else begin
            pick = $urandom_range(0, open_seqs.size() - 1);
            send_item(MODE_COMPLETE, open_seqs[pick], $urandom);
            open_seqs.delete(pick);
         end
      end
   endtask

   initial begin : stimulus
      logic [31:0] fill_seq [DEPTH + 1];
      int unsigned random_start;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data      <= '0;
      hold_rsp      = 1'b0;
      req_calm      = 1'b0;
      req_calm_left = 0;
      items_sent    = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_item(MODE_COMPLETE, 32'h0, 32'hFFFF_FFFF);    // nothing outstanding
      send_item(MODE_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(MODE_RECORD, 32'h0, 32'h0);
      send_item(MODE_RECORD, 32'd5, 32'h0000_0001);
      send_item(MODE_RECORD, 32'd5, 32'h8000_0000);      // duplicate seq
      send_item(MODE_COMPLETE, 32'd5, 32'h0);            // older copy, head still open
      send_item(MODE_COMPLETE, 32'd5, 32'h0);            // younger copy
      send_item(MODE_COMPLETE, 32'd5, 32'h0);            // no open copy left
      send_item(MODE_COMPLETE, 32'h0, 32'h0);
      send_item(MODE_COMPLETE, 32'hFFFF_FFFF, 32'h0);    // retires all four
      send_item(MODE_COMPLETE, 32'hFFFF_FFFF, 32'h0);    // already retired

      // fill to capacity under a long result hold-off, overflow once, then
      // complete back to front so the head completion retires everything
      pause_until_drained();
      hold_rsp = 1'b1;
      @(posedge clock);
      for (int i = 0; i <= DEPTH; i++) begin
         fill_seq[i] = $urandom;
         send_item(MODE_RECORD, fill_seq[i], $urandom);
      end
      for (int i = DEPTH - 1; i >= 0; i--) begin
         send_item(MODE_COMPLETE, fill_seq[i], $urandom);
      end

      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         run_batch();
         if ($urandom_range(0, 3) == 0) begin
            pause_until_drained();
         end
      end

      pause_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
